// File: rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, status codes and default sizes for the message mailbox engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  // Default sizes
  localparam int unsigned DefNumSlots  = 1024;
  localparam int unsigned DefNumQueues = 64;
  localparam int unsigned DefQueueDepth = 512;

  // Operation codes
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic        operation;
    logic [5:0]  queue_id;
    logic [63:0] message_in;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] message_out;
    logic [9:0]  slot_used;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic sweep;
    logic capture;
    logic decide;
    logic send_commit;
    logic ent_read;
    logic recv_commit;
    logic walk_step;
    logic load_out;
  } mme_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    sweep_done;
    status_e decide_status;
    logic    is_recv;
    logic    walk_last;
  } mme_stat_t;

endpackage

// File: rtl/mme_datapath.sv
// ----------------------------------------------------------------------------
// mme_datapath
// Slot pool min-tree, message store, queue entry store, queue pointers and
// the result register.
// ----------------------------------------------------------------------------
module mme_datapath #(
  parameter int unsigned NUM_SLOTS   = mme_pkg::DefNumSlots,
  parameter int unsigned NUM_QUEUES  = mme_pkg::DefNumQueues,
  parameter int unsigned QUEUE_DEPTH = mme_pkg::DefQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mme_pkg::in_item_t  in_data_i,
  input  mme_pkg::mme_cmd_t  cmd_i,
  output mme_pkg::mme_stat_t stat_o,
  output mme_pkg::out_item_t out_data_o
);
  import mme_pkg::*;

  localparam int unsigned SIW   = $clog2(NUM_SLOTS);
  localparam int unsigned NW    = SIW + 1;
  localparam int unsigned LEAF  = 1 << SIW;
  localparam int unsigned TW    = $clog2(NUM_SLOTS + 1);
  localparam int unsigned QW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned SWEEP = (2 * LEAF > NUM_QUEUES) ? 2 * LEAF : NUM_QUEUES;
  localparam int unsigned CW    = $clog2(SWEEP + 1);
  localparam int unsigned SHW   = $clog2(SIW + 2);

  // Storage
  logic [TW-1:0]   tree_mem [2*LEAF];
  logic [2*QW-1:0] ht_mem   [NUM_QUEUES];
  logic [SIW-1:0]  ent_mem  [NUM_QUEUES << QW];
  logic [63:0]     msg_mem  [NUM_SLOTS];

  logic [TW-1:0]   tree_rdata_q;
  logic [2*QW-1:0] ht_rdata_q;
  logic [SIW-1:0]  ent_rdata_q;
  logic [63:0]     msg_rdata_q;

  in_item_t        item_q;
  logic [TW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic [SHW-1:0]  shift_q;
  logic [NW-1:0]   node_q;
  logic [TW-1:0]   cur_q;
  logic [SIW-1:0]  slot_q;
  status_e         status_q;
  out_item_t       out_q;

  logic [QIW-1:0]  qidx;
  logic [QW-1:0]   head, tail, head_next, tail_next;
  logic            qvalid;
  status_e         dec_status;
  logic [NW-1:0]   left, parent, root_leaf, ent_leaf;
  logic [SIW-1:0]  sw_slot;
  logic [TW-1:0]   sw_val, wmin;
  logic            t_we, t_re;
  logic [NW-1:0]   t_waddr, t_raddr;
  logic [TW-1:0]   t_wdata;

  // Queue pointer arithmetic
  assign qidx      = QIW'(item_q.queue_id);
  assign head      = ht_rdata_q[2*QW-1:QW];
  assign tail      = ht_rdata_q[QW-1:0];
  assign tail_next = (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign head_next = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign qvalid    = ({5'b0, item_q.queue_id} < 11'(NUM_QUEUES));

  // Classify the pending item
  always_comb begin
    if (item_q.operation == OP_SEND) begin
      if (!qvalid) begin
        dec_status = ST_FULL;
      end else if (root_q == TW'(NUM_SLOTS)) begin
        dec_status = ST_NO_SLOT;
      end else if (tail_next == head) begin
        dec_status = ST_FULL;
      end else begin
        dec_status = ST_OK;
      end
    end else begin
      dec_status = (!qvalid || head == tail) ? ST_EMPTY : ST_OK;
    end
  end

  // Build value of one tree node during the reset sweep
  assign left    = NW'(cnt_q[NW-1:0] << shift_q);
  assign sw_slot = left[SIW-1:0];
  assign sw_val  = ({1'b0, sw_slot} < NW'(NUM_SLOTS)) ? TW'(sw_slot) : TW'(NUM_SLOTS);

  assign parent    = node_q >> 1;
  assign root_leaf = {1'b1, root_q[SIW-1:0]};
  assign ent_leaf  = {1'b1, ent_rdata_q};
  assign wmin      = (cur_q <= tree_rdata_q) ? cur_q : tree_rdata_q;

  // Tree port select
  always_comb begin
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_re    = 1'b0;
    t_raddr = '0;
    if (cmd_i.sweep) begin
      t_we    = (cnt_q != '0) && (cnt_q < CW'(2 * LEAF));
      t_waddr = cnt_q[NW-1:0];
      t_wdata = sw_val;
    end else if (cmd_i.send_commit) begin
      t_we    = 1'b1;
      t_waddr = root_leaf;
      t_wdata = TW'(NUM_SLOTS);
      t_re    = 1'b1;
      t_raddr = root_leaf ^ NW'(1);
    end else if (cmd_i.recv_commit) begin
      t_we    = 1'b1;
      t_waddr = ent_leaf;
      t_wdata = TW'(ent_rdata_q);
      t_re    = 1'b1;
      t_raddr = ent_leaf ^ NW'(1);
    end else if (cmd_i.walk_step) begin
      t_we    = 1'b1;
      t_waddr = parent;
      t_wdata = wmin;
      t_re    = 1'b1;
      t_raddr = parent ^ NW'(1);
    end
  end

  // Tree memory
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tree_mem[t_waddr] <= t_wdata;
    end
    if (t_re) begin
      tree_rdata_q <= tree_mem[t_raddr];
    end
  end

  // Queue pointer memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep && cnt_q < CW'(NUM_QUEUES)) begin
      ht_mem[cnt_q[QIW-1:0]] <= '0;
    end else if (cmd_i.send_commit) begin
      ht_mem[qidx] <= {head, tail_next};
    end else if (cmd_i.recv_commit) begin
      ht_mem[qidx] <= {head_next, tail};
    end
    if (cmd_i.capture) begin
      ht_rdata_q <= ht_mem[QIW'(in_data_i.queue_id)];
    end
  end

  // Queue entry memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.send_commit) begin
      ent_mem[{qidx, tail}] <= root_q[SIW-1:0];
    end
    if (cmd_i.ent_read) begin
      ent_rdata_q <= ent_mem[{qidx, head}];
    end
  end

  // Message memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.send_commit) begin
      msg_mem[root_q[SIW-1:0]] <= item_q.message_in;
    end
    if (cmd_i.recv_commit) begin
      msg_rdata_q <= msg_mem[ent_rdata_q];
    end
  end

  // Sweep counter, sweep shift and tree root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      shift_q <= SHW'(SIW + 1);
      root_q  <= '0;
    end else begin
      if (cmd_i.sweep) begin
        cnt_q <= cnt_q + 1'b1;
        if (((cnt_q + 1'b1) & cnt_q) == '0 && shift_q != '0) begin
          shift_q <= shift_q - 1'b1;
        end
        root_q <= '0;
      end else if (cmd_i.walk_step && parent == NW'(1)) begin
        root_q <= wmin;
      end
    end
  end

  // Item, walk and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.decide) begin
      status_q <= dec_status;
    end
    if (cmd_i.send_commit) begin
      slot_q <= root_q[SIW-1:0];
      node_q <= root_leaf;
      cur_q  <= TW'(NUM_SLOTS);
    end else if (cmd_i.recv_commit) begin
      slot_q <= ent_rdata_q;
      node_q <= ent_leaf;
      cur_q  <= TW'(ent_rdata_q);
    end else if (cmd_i.walk_step) begin
      node_q <= parent;
      cur_q  <= wmin;
    end
    if (cmd_i.load_out) begin
      out_q.status      <= status_q;
      out_q.message_out <= (status_q == ST_OK && item_q.operation == OP_RECV) ?
                           msg_rdata_q : 64'd0;
      out_q.slot_used   <= (status_q == ST_OK) ? 10'(slot_q) : 10'd0;
    end
  end

  assign stat_o.sweep_done    = (cnt_q == CW'(SWEEP - 1));
  assign stat_o.decide_status = dec_status;
  assign stat_o.is_recv       = (item_q.operation == OP_RECV);
  assign stat_o.walk_last     = (parent == NW'(1));
  assign out_data_o           = out_q;

endmodule

// File: rtl/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer for the mailbox: reset sweep, decision, commit, tree walk and
// result handoff.
// ----------------------------------------------------------------------------
module mme_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mme_pkg::mme_stat_t stat_i,
  output mme_pkg::mme_cmd_t  cmd_o
);
  import mme_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_ENTRY,
    S_WALK,
    S_RESPOND
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Command decode
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_INIT:    cmd_o.sweep = 1'b1;
      S_IDLE:    cmd_o.capture = in_valid_i;
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.decide_status == ST_OK) begin
          cmd_o.ent_read    = stat_i.is_recv;
          cmd_o.send_commit = !stat_i.is_recv;
        end
      end
      S_ENTRY:   cmd_o.recv_commit = 1'b1;
      S_WALK:    cmd_o.walk_step = 1'b1;
      S_RESPOND: cmd_o.load_out = !out_valid_q || !out_stall_i;
      default:   cmd_o = '0;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          if (stat_i.sweep_done) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (stat_i.decide_status != ST_OK) begin
            state_q <= S_RESPOND;
          end else if (stat_i.is_recv) begin
            state_q <= S_ENTRY;
          end else begin
            state_q <= S_WALK;
          end
        end
        S_ENTRY:   state_q <= S_WALK;
        S_WALK: begin
          if (stat_i.walk_last) state_q <= S_RESPOND;
        end
        S_RESPOND: begin
          if (cmd_o.load_out) state_q <= S_IDLE;
        end
        default:   state_q <= S_INIT;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/message_mailbox_engine.sv
// ----------------------------------------------------------------------------
// message_mailbox_engine
// Mailbox with a shared pool of 8-byte message slots and circular receiver
// queues.
// ----------------------------------------------------------------------------
// One item at a time. A refused send or receive skips the tree walk; a
// successful send or receive walks up the free-slot min-tree, one level per
// cycle through its single read and write port. After reset the block runs
// a build pass over the tree and the queue pointers with in_stall_o high. A
// finished result waits in an output register, and the next item is taken
// meanwhile.
module message_mailbox_engine
  import mme_pkg::*;
#(
  parameter int unsigned NUM_SLOTS   = DefNumSlots,
  parameter int unsigned NUM_QUEUES  = DefNumQueues,
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mme_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mme_pkg::out_item_t out_data_o
);

  mme_cmd_t  cmd;
  mme_stat_t stat;

  // Sequencer
  mme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic
  mme_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/mme_checker.sv
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks on the mailbox, bound to the top level.
// ----------------------------------------------------------------------------
module mme_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input mme_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mme_pkg::out_item_t out_data_o
);
  import mme_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // Hold a stalled input transfer
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> $stable(in_data_i))
    else $error("stalled input payload changed");

  // Close the input after a transfer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // Refused operations carry no message
  a_refused_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.message_out == 64'd0)
    else $error("message on refused operation");

  // Refused operations report slot zero
  a_refused_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.slot_used == 10'd0)
    else $error("slot on refused operation");

endmodule

bind message_mailbox_engine mme_checker u_mme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: dv/tb_message_mailbox_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_mailbox_engine
// Self-checking bench for the mailbox engine: a directed table of sends and
// receives, then random traffic, each result checked against a behavioral
// model of the slot pool, the free-slot search and the receiver queues.
// ----------------------------------------------------------------------------
module tb_message_mailbox_engine;
  import mme_pkg::*;

  localparam int unsigned Slots     = DefNumSlots;
  localparam int unsigned Queues    = DefNumQueues;
  localparam int unsigned Depth     = DefQueueDepth;
  localparam int unsigned NumRandom = 360;
  localparam longint     CycleLimit = 2000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;

  message_mailbox_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mailbox model state
  bit          slot_busy [Slots];
  logic [63:0] slot_msg  [Slots];
  logic [9:0]  ring      [Queues][Depth];
  int unsigned ring_head [Queues];
  int unsigned ring_tail [Queues];

  out_item_t   pending_results[$];
  int          fail_count = 0;
  int          result_count = 0;
  int          sends_ok = 0, recvs_ok = 0, refused = 0;
  longint      cycle_count = 0;
  bit          idle_free = 1'b0;

  function automatic int unsigned lowest_free_slot();
    for (int unsigned s = 0; s < Slots; s++) begin
      if (!slot_busy[s]) return s;
    end
    return Slots;
  endfunction

  function automatic int unsigned ring_fill(int unsigned q);
    return (ring_tail[q] + Depth - ring_head[q]) % Depth;
  endfunction

  // Compute the result of one operation and advance the model
  function automatic out_item_t mailbox_apply(in_item_t it);
    out_item_t   r;
    int unsigned q, nxt, low;
    r = '0;
    q = it.queue_id;
    if (it.operation == OP_SEND) begin
      nxt = (ring_tail[q] + 1) % Depth;
      low = lowest_free_slot();
      if (q >= Queues) r.status = ST_FULL;
      else if (low >= Slots) r.status = ST_NO_SLOT;
      else if (nxt == ring_head[q]) r.status = ST_FULL;
      else begin
        slot_busy[low] = 1'b1;
        slot_msg[low] = it.message_in;
        ring[q][ring_tail[q]] = low[9:0];
        ring_tail[q] = nxt;
        r.status = ST_OK;
        r.slot_used = low[9:0];
      end
    end else begin
      if (q >= Queues || ring_head[q] == ring_tail[q]) r.status = ST_EMPTY;
      else begin
        r.slot_used = ring[q][ring_head[q]];
        r.message_out = slot_msg[r.slot_used];
        slot_busy[r.slot_used] = 1'b0;
        ring_head[q] = (ring_head[q] + 1) % Depth;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  // Hold the item until transferred, then queue its expected result
  task automatic push_item(in_item_t it);
    @(negedge clk_i);
    while (!idle_free && $urandom_range(99) < 7) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(mailbox_apply(it));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic op, int unsigned q, logic [63:0] m);
    in_item_t it;
    it.operation = op;
    it.queue_id = q[5:0];
    it.message_in = m;
    return it;
  endfunction

  function automatic logic [63:0] rand_msg();
    return {$urandom, $urandom};
  endfunction

  // Drive receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= !idle_free && ($urandom_range(99) < 7);
  end

  // Check each transferred result against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count <= result_count + 1;
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        fail_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.message_out !== want.message_out) begin
          $error("message_out: expected %h, got %h", want.message_out,
                 out_data_o.message_out);
          fail_count++;
        end
        if (out_data_o.slot_used !== want.slot_used) begin
          $error("slot_used: expected %0d, got %0d", want.slot_used,
                 out_data_o.slot_used);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Directed table: operation, queue, message, typed expected status
  typedef struct {
    logic        op;
    int unsigned q;
    logic [63:0] msg;
    bit          has_want;
    status_e     want;
  } step_row_t;

  step_row_t steps[] = '{
    '{OP_RECV, 0,  64'hFFFF_FFFF_FFFF_FFFF, 1, ST_EMPTY},
    '{OP_RECV, 63, 64'h0,                   1, ST_EMPTY},
    '{OP_SEND, 0,  64'h0,                   1, ST_OK},
    '{OP_SEND, 0,  64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK},
    '{OP_SEND, 63, 64'h0123_4567_89AB_CDEF, 1, ST_OK},
    '{OP_RECV, 0,  64'hFFFF_FFFF_FFFF_FFFF, 0, ST_OK},
    '{OP_SEND, 5,  64'hA5A5_5A5A_A5A5_5A5A, 0, ST_OK},
    '{OP_RECV, 63, 64'h0,                   0, ST_OK},
    '{OP_RECV, 0,  64'h0,                   0, ST_OK},
    '{OP_RECV, 5,  64'h0,                   0, ST_OK},
    '{OP_RECV, 5,  64'h0,                   1, ST_EMPTY}
  };

  initial begin
    out_item_t   got_status;
    int unsigned q, fill_cnt;
    logic        op;
    for (int i = 0; i < Queues; i++) begin
      ring_head[i] = 0;
      ring_tail[i] = 0;
    end
    for (int i = 0; i < Slots; i++) slot_busy[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (steps[i]) begin
      push_item(make_item(steps[i].op, steps[i].q, steps[i].msg));
      got_status = pending_results[$];
      if (steps[i].has_want && got_status.status != steps[i].want) begin
        $error("table row %0d: status expected %0d, model gives %0d", i,
               steps[i].want, got_status.status);
        fail_count++;
      end
    end

    // Fill queue 1 to its limit, then one more for queue full
    for (int i = 0; i < Depth; i++) push_item(make_item(OP_SEND, 1, rand_msg()));
    // Exhaust the pool across other queues, then provoke no free slot
    q = 2;
    while (lowest_free_slot() < Slots) begin
      push_item(make_item(OP_SEND, q, rand_msg()));
      if (ring_fill(q) == Depth - 1) q++;
    end
    push_item(make_item(OP_SEND, 40, rand_msg()));
    push_item(make_item(OP_SEND, 1, rand_msg()));

    // Wait for all results before the random mix
    while (pending_results.size() != 0) @(negedge clk_i);

    // Random traffic on a few busy queues, with a quiet stretch of no idling
    for (int n = 0; n < NumRandom; n++) begin
      idle_free = (n >= 100 && n < 250);
      q = ($urandom_range(3) == 0) ? $urandom_range(Queues - 1) : $urandom_range(3);
      op = ($urandom_range(99) < 55) ? OP_SEND : OP_RECV;
      push_item(make_item(op, q, rand_msg()));
    end
    idle_free = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    fill_cnt = 0;
    for (int i = 0; i < Slots; i++) fill_cnt += slot_busy[i];
    $display("covered %0d results: table, full queue, empty pool, random mix",
             result_count);
    $display("slots still held at end: %0d", fill_cnt);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
